// ===== sv/telemetry_frame_sample_unpacker_assert.svh =====
// assertion macros for the telemetry frame sample unpacker checker
// no dependencies; included by the checker file
`ifndef TELEMETRY_FRAME_SAMPLE_UNPACKER_ASSERT_SVH
`define TELEMETRY_FRAME_SAMPLE_UNPACKER_ASSERT_SVH

// clocked assertion, switched off while reset is high
`define TFSU_ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds through reset
`define TFSU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/tfsu_pkg.sv =====
// shared types, constants and helper functions for the telemetry frame sample unpacker
// no dependencies; imported by tfsu_tracker and the top level
`default_nettype none

package tfsu_pkg;

  localparam logic [4:0] HDR_LAST     = 5'd16;  // 17 header bytes
  localparam logic [4:0] TAIL_LAST    = 5'd5;   // 6 tail bytes
  localparam logic [4:0] REC_HDR      = 5'd5;   // hour, minute, second, millis
  localparam logic [4:0] REC_POS_END0 = 5'd24;  // 25-byte records
  localparam logic [4:0] REC_POS_END1 = 5'd29;  // 30-byte records
  localparam logic [5:0] REC_CNT_END0 = 6'd39;  // 40 records
  localparam logic [5:0] REC_CNT_END1 = 6'd32;  // 33 records

  // register index, taken from paddr[2]
  localparam logic REG_FRAME_MODE = 1'b0;

  localparam int OUT_W = 64;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_RECORDS = 3'b010,
    PH_TAIL    = 3'b100
  } phase_t;

  typedef struct packed {
    logic        valid;
    logic [4:0]  channel;
    logic [9:0]  code;
    logic [5:0]  rec_idx;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
    logic [15:0] millis;
    logic        last_rec;
    logic        last_frame;
  } smp_t;

  // position of a byte within its 5-byte sample group
  function automatic logic [2:0] slot_of(input logic [4:0] pos);
    logic [2:0] s;
    case (pos) inside
      5'd6, 5'd11, 5'd16, 5'd21, 5'd26, 5'd31: s = 3'd1;
      5'd7, 5'd12, 5'd17, 5'd22, 5'd27:        s = 3'd2;
      5'd8, 5'd13, 5'd18, 5'd23, 5'd28:        s = 3'd3;
      5'd9, 5'd14, 5'd19, 5'd24, 5'd29:        s = 3'd4;
      default:                                 s = 3'd0;
    endcase
    return s;
  endfunction

  // big-endian 10-bit merge of the previous and current byte
  function automatic logic [9:0] unpack(input logic [2:0] slot,
                                        input logic [7:0] prev,
                                        input logic [7:0] cur);
    logic [9:0] v;
    case (slot)
      3'd1:    v = {prev, cur[7:6]};
      3'd2:    v = {prev[5:0], cur[7:4]};
      3'd3:    v = {prev[3:0], cur[7:2]};
      default: v = {prev[1:0], cur};
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== sv/tfsu_tracker.sv =====
// frame position tracker: phase, counters, record header capture and sample merge
// depends on tfsu_pkg
`default_nettype none

module tfsu_tracker import tfsu_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       adv,
  input  wire logic [7:0] data_byte,
  input  wire logic       frame_mode,
  output smp_t            smp
);

  phase_t      phase, phase_next;
  logic [4:0]  phase_cnt, phase_cnt_next;
  logic [5:0]  rec_cnt, rec_cnt_next;
  logic [4:0]  rec_pos, rec_pos_next;
  logic [4:0]  chan, chan_next;
  logic [7:0]  prev_byte;
  logic [7:0]  hour, minute, second;
  logic [15:0] millis;

  logic [4:0] pos_end;
  logic [5:0] cnt_end;
  logic       end_rec, end_frame;
  logic [2:0] slot;
  logic       is_sample;

  assign pos_end   = frame_mode ? REC_POS_END1 : REC_POS_END0;
  assign cnt_end   = frame_mode ? REC_CNT_END1 : REC_CNT_END0;
  assign end_rec   = rec_pos >= pos_end;
  assign end_frame = end_rec && (rec_cnt >= cnt_end);
  assign slot      = slot_of(rec_pos);
  assign is_sample = (phase == PH_RECORDS) && (rec_pos >= REC_HDR) && (slot != 3'd0);

  always_comb begin
    smp.valid      = is_sample;
    smp.channel    = chan;
    smp.code       = unpack(slot, prev_byte, data_byte);
    smp.rec_idx    = rec_cnt;
    smp.hour       = hour;
    smp.minute     = minute;
    smp.second     = second;
    smp.millis     = millis;
    smp.last_rec   = end_rec;
    smp.last_frame = end_frame;
  end

  always_comb begin
    phase_next     = phase;
    phase_cnt_next = phase_cnt;
    rec_cnt_next   = rec_cnt;
    rec_pos_next   = rec_pos;
    chan_next      = chan;
    unique case (phase)
      PH_RECORDS: begin
        if (is_sample) begin
          chan_next = chan + 5'd1;
        end
        if (end_rec) begin
          rec_pos_next = '0;
          chan_next    = '0;
          if (end_frame) begin
            rec_cnt_next   = '0;
            phase_cnt_next = '0;
            phase_next     = frame_mode ? PH_TAIL : PH_HEADER;
          end else begin
            rec_cnt_next = rec_cnt + 6'd1;
          end
        end else begin
          rec_pos_next = rec_pos + 5'd1;
        end
      end
      PH_TAIL: begin
        if (phase_cnt >= TAIL_LAST) begin
          phase_cnt_next = '0;
          phase_next     = PH_HEADER;
        end else begin
          phase_cnt_next = phase_cnt + 5'd1;
        end
      end
      default: begin
        // header, and any stray code
        if (phase_cnt >= HDR_LAST) begin
          phase_cnt_next = '0;
          phase_next     = PH_RECORDS;
          rec_cnt_next   = '0;
          rec_pos_next   = '0;
          chan_next      = '0;
        end else begin
          phase_cnt_next = phase_cnt + 5'd1;
          phase_next     = PH_HEADER;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEADER;
      phase_cnt <= '0;
      rec_cnt   <= '0;
      rec_pos   <= '0;
      chan      <= '0;
    end else if (adv) begin
      phase     <= phase_next;
      phase_cnt <= phase_cnt_next;
      rec_cnt   <= rec_cnt_next;
      rec_pos   <= rec_pos_next;
      chan      <= chan_next;
    end
  end

  // header capture and byte history
  always_ff @(posedge clk) begin
    if (adv) begin
      prev_byte <= data_byte;
      if (phase == PH_RECORDS) begin
        case (rec_pos)
          5'd0:    hour          <= data_byte;
          5'd1:    minute        <= data_byte;
          5'd2:    second        <= data_byte;
          5'd3:    millis[15:8]  <= data_byte;
          5'd4:    millis[7:0]   <= data_byte;
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/telemetry_frame_sample_unpacker.sv =====
// top level of the telemetry frame sample unpacker: handshakes, register port, result register
// depends on tfsu_pkg and tfsu_tracker
//
//  channel   | dir | handshake            | contents
//  ----------+-----+----------------------+------------------------------------------
//  s_*       | in  | s_tvalid / s_tready  | one stream byte per item
//  m_*       | out | m_tvalid / m_tready  | one unpacked sample per item
//  apb       | in  | psel/penable/pready  | frame_mode at byte address 0
//
//  one byte is taken per cycle while the result register is not stalled; a
//  sample appears in the result register the cycle after the byte that completes it
//  the result register is the only stage: a new byte is taken whenever the
//  register is empty or is being drained in the same cycle
//  header, tail and record-header bytes update the tracker and give no item
//  rst is synchronous and clears the phase tracker, counters and valid flag
`default_nettype none

module telemetry_frame_sample_unpacker import tfsu_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  // input stream
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [7:0]       s_tdata,   // [7:0] data_byte
  // output stream
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [OUT_W-1:0]      m_tdata,   // [4:0] channel, [14:5] sample_code,
                                           // [20:15] record_index, [28:21] rec_hour,
                                           // [36:29] rec_minute, [44:37] rec_second,
                                           // [60:45] rec_millis, [63:61] zero
  output logic                  m_tlast,   // last_of_record
  output logic                  m_tuser,   // last_of_frame
  // register port
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic frame_mode;
  logic adv;
  smp_t smp;

  // register port: always ready, one register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_FRAME_MODE)) begin
      frame_mode <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_FRAME_MODE) begin
      prdata[0] = frame_mode;
    end
  end

  // take a byte whenever the result register can hold what it produces
  assign s_tready = !m_tvalid || m_tready;
  assign adv      = s_tvalid && s_tready;

  tfsu_tracker u_tracker (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .data_byte  (s_tdata),
    .frame_mode (frame_mode),
    .smp        (smp)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= smp.valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && smp.valid) begin
      m_tdata <= {3'b000, smp.millis, smp.second, smp.minute, smp.hour,
                  smp.rec_idx, smp.code, smp.channel};
      m_tlast <= smp.last_rec;
      m_tuser <= smp.last_frame;
    end
  end

endmodule

`default_nettype wire

// ===== sv/tfsu_checker.sv =====
// port-level checker for the telemetry frame sample unpacker, bound to the top level
// depends on telemetry_frame_sample_unpacker_assert.svh
`include "telemetry_frame_sample_unpacker_assert.svh"
`default_nettype none

module tfsu_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [63:0] m_tdata,
  input wire logic        m_tlast,
  input wire logic        m_tuser
);

  // an empty result register never holds back the input
  `TFSU_ASSERT_CLK(a_ready_when_empty, clk, rst, !m_tvalid |-> s_tready, "input stalled with empty output")

  // end of frame only on the end of a record
  `TFSU_ASSERT_CLK(a_frame_end_is_rec_end, clk, rst, (m_tvalid && m_tuser) |-> m_tlast, "frame end without record end")

  // channel and record number stay in range
  `TFSU_ASSERT_CLK(a_fields_range, clk, rst, m_tvalid |-> ((m_tdata[4:0] <= 5'd19) && (m_tdata[20:15] <= 6'd39)), "sample tag out of range")

  // a stalled sample holds
  `TFSU_ASSERT_CLK(a_out_hold, clk, rst, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "stalled sample changed")

  // nothing shows right after reset
  `TFSU_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid, "output valid after reset")

endmodule

bind telemetry_frame_sample_unpacker tfsu_checker u_tfsu_checker (.*);

`default_nettype wire
